// ----- sv/md4_pkg.sv -----
// Shared types, constants and schedule functions for the MD4 compression block.
package md4_pkg;

  localparam logic [31:0] K_ROUND2 = 32'h5A82_7999;
  localparam logic [31:0] K_ROUND3 = 32'h6ED9_EBA1;

  localparam logic [1:0] RND_F = 2'd0;
  localparam logic [1:0] RND_G = 2'd1;
  localparam logic [1:0] RND_H = 2'd2;

  localparam logic KIND_CHAIN = 1'b0;
  localparam logic KIND_MSG   = 1'b1;

  localparam int TDATA_W = 40;

  typedef struct packed {
    logic [1:0] rnd;
    logic [1:0] pos;
  } step_ctl_t;

  // Message word order: identity, 4x4 transpose, bit reversal.
  function automatic logic [3:0] msg_index(input logic [1:0] rnd, input logic [3:0] i);
    logic [3:0] idx;
    case (rnd)
      RND_F:   idx = i;
      RND_G:   idx = {i[1:0], i[3:2]};
      RND_H:   idx = {i[0], i[1], i[2], i[3]};
      default: idx = i;
    endcase
    return idx;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [1:0] rnd, input logic [1:0] pos);
    logic [4:0] s;
    case ({rnd, pos})
      {RND_F, 2'd0}: s = 5'd3;
      {RND_F, 2'd1}: s = 5'd7;
      {RND_F, 2'd2}: s = 5'd11;
      {RND_F, 2'd3}: s = 5'd19;
      {RND_G, 2'd0}: s = 5'd3;
      {RND_G, 2'd1}: s = 5'd5;
      {RND_G, 2'd2}: s = 5'd9;
      {RND_G, 2'd3}: s = 5'd13;
      {RND_H, 2'd0}: s = 5'd3;
      {RND_H, 2'd1}: s = 5'd9;
      {RND_H, 2'd2}: s = 5'd11;
      {RND_H, 2'd3}: s = 5'd15;
      default:       s = 5'd0;
    endcase
    return s;
  endfunction

endpackage

// ----- sv/md4_compression.sv -----
// MD4 compression top level: word loading, step sequencer and digest output.
// After the message word 15 transfer, the step sequencer runs all steps on the
// single step unit, then does the chaining add, then outputs the digest words.
// A new block cannot be taken while one is in progress: input
// is not ready from word 15 until the fourth digest word is taken.
// Reset (rst, synchronous, active high) clears the chaining words and sequencer.
module md4_compression (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [md4_pkg::TDATA_W-1:0]   s_axis_tdata,  // word_index[3:0], word_value[35:4]
  input  logic                          s_axis_tuser,  // kind
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [md4_pkg::TDATA_W-1:0]   m_axis_tdata,  // digest_index[1:0], digest_word[33:2]
  output logic                          m_axis_tlast
);
  import md4_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_SUM  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]  state;
  logic [5:0]  cnt;
  logic [1:0]  oidx;
  logic [31:0] chain [4];
  logic [31:0] msg   [16];
  logic [31:0] va, vb, vc, vd;
  logic [31:0] step_out;
  logic [31:0] m_word;
  step_ctl_t   ctl;

  logic        in_xfer;
  logic        out_xfer;
  logic [3:0]  in_idx;
  logic [31:0] in_val;

  assign in_idx   = s_axis_tdata[3:0];
  assign in_val   = s_axis_tdata[35:4];
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  assign ctl     = {cnt[5:4], cnt[1:0]};
  assign m_word  = msg[msg_index(cnt[5:4], cnt[3:0])];

  md4_step u_step (
    .ctl    (ctl),
    .a      (va),
    .b      (vb),
    .c      (vc),
    .d      (vd),
    .m      (m_word),
    .result (step_out)
  );

  always_ff @(posedge clk) begin
    if (in_xfer && s_axis_tuser == KIND_MSG) begin
      msg[in_idx] <= in_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      oidx  <= '0;
      for (int i = 0; i < 4; i++) begin
        chain[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            if (s_axis_tuser == KIND_CHAIN) begin
              if (in_idx[3:2] == 2'b00) begin
                chain[in_idx[1:0]] <= in_val;
              end
            end else if (in_idx == 4'hF) begin
              state <= ST_RUN;
              cnt   <= '0;
            end
          end
        end
        ST_RUN: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd47) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          chain[0] <= chain[0] + va;
          chain[1] <= chain[1] + vb;
          chain[2] <= chain[2] + vc;
          chain[3] <= chain[3] + vd;
          oidx     <= '0;
          state    <= ST_OUT;
        end
        ST_OUT: begin
          if (out_xfer) begin
            oidx <= oidx + 2'd1;
            if (oidx == 2'd3) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Working variables rotate (a,b,c,d) <= (d,new,b,c) each step.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_xfer && s_axis_tuser == KIND_MSG && in_idx == 4'hF) begin
      va <= chain[0];
      vb <= chain[1];
      vc <= chain[2];
      vd <= chain[3];
    end else if (state == ST_RUN) begin
      va <= vd;
      vb <= step_out;
      vc <= vb;
      vd <= vc;
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = {{(TDATA_W - 34){1'b0}}, chain[oidx], oidx};
  assign m_axis_tlast  = (oidx == 2'd3);

endmodule

// ----- sv/md4_step.sv -----
// MD4 step unit: boolean function, constant, message add and rotate.
module md4_step (
  input  md4_pkg::step_ctl_t ctl,
  input  logic [31:0]        a,
  input  logic [31:0]        b,
  input  logic [31:0]        c,
  input  logic [31:0]        d,
  input  logic [31:0]        m,
  output logic [31:0]        result
);
  import md4_pkg::*;

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] sum;
  logic [4:0]  s;
  logic [63:0] rot;

  always_comb begin
    case (ctl.rnd)
      RND_F: begin
        f = d ^ (b & (c ^ d));
        k = 32'd0;
      end
      RND_G: begin
        f = (b & c) | (b & d) | (c & d);
        k = K_ROUND2;
      end
      RND_H: begin
        f = b ^ c ^ d;
        k = K_ROUND3;
      end
      default: begin
        f = 32'd0;
        k = 32'd0;
      end
    endcase
  end

  assign sum    = a + f + k + m;
  assign s      = rot_amount(ctl.rnd, ctl.pos);
  assign rot    = {sum, sum} << s;
  assign result = rot[63:32];

endmodule

// ----- sv/md4_checker.sv -----
// Port-level checker for the MD4 compression block, bound to the top level.
module md4_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [md4_pkg::TDATA_W-1:0]   s_axis_tdata,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [md4_pkg::TDATA_W-1:0]   m_axis_tdata,
  input logic                          m_axis_tlast
);
  import md4_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled output transfer changed");

  a_busy_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while digest pending");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_MSG
      && s_axis_tdata[3:0] == 4'hF |=> !s_axis_tready && !m_axis_tvalid)
    else $error("block not busy after word 15");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid && s_axis_tready)
    else $error("output continued after last word");

endmodule

bind md4_compression md4_checker u_md4_checker (.*);
